### design/i2a_fmt_pkg.sv
// Package for the integer to ASCII formatter.
// Word types, operation codes, character constants and the controller/datapath link.
// No dependencies.
package i2a_fmt_pkg;

    localparam int WORD_BITS_DEF = 32;

    localparam logic [2:0] OP_LITERAL = 3'd0;
    localparam logic [2:0] OP_SDEC    = 3'd1;
    localparam logic [2:0] OP_UDEC    = 3'd2;
    localparam logic [2:0] OP_HEX_LO  = 3'd3;
    localparam logic [2:0] OP_HEX_UP  = 3'd4;
    localparam logic [2:0] OP_BIN     = 3'd5;
    localparam logic [2:0] OP_CHAR    = 3'd6;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [3:0] NIB_MASK = 4'hF;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] value;
    } t_fmt_req;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_fmt_char;

    typedef enum logic [1:0] {
        SEL_LOW,
        SEL_CR,
        SEL_MINUS,
        SEL_DIGIT
    } t_emit_sel;

    // controller -> datapath
    typedef struct packed {
        logic      load;
        logic      conv;
        logic      skip;
        logic      shift_digit;
        logic      emit;
        t_emit_sel sel;
        logic      last;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] op;
        logic       is_nl;
        logic       neg;
        logic       conv_done;
        logic       lead_zero;
        logic       last_digit;
        logic       out_free;
    } t_dp_sts;

endpackage

### design/i2a_fmt_ctrl.sv
// Sequencer of the integer to ASCII formatter.
// Depends on i2a_fmt_pkg; drives the datapath in i2a_fmt_dp.
module i2a_fmt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [2:0]           i_in_op,
    output logic                 o_in_ready,
    input  i2a_fmt_pkg::t_dp_sts i_sts,
    output i2a_fmt_pkg::t_dp_cmd o_cmd
);
    import i2a_fmt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOW,
        S_CR,
        S_SIGN,
        S_CONV,
        S_SKIP,
        S_DIGIT
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.sel        = SEL_DIGIT;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_in_op)
                        OP_LITERAL, OP_CHAR:   n_state = S_LOW;
                        OP_SDEC:               n_state = S_SIGN;
                        OP_UDEC:               n_state = S_CONV;
                        OP_HEX_LO, OP_HEX_UP:  n_state = S_DIGIT;
                        OP_BIN:                n_state = S_SKIP;
                        default:               n_state = S_IDLE; // unused code: no output
                    endcase
                end
            end
            S_LOW: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_LOW;
                    // a literal newline gets a trailing carriage return
                    if (i_sts.op == OP_LITERAL && i_sts.is_nl) begin
                        o_cmd.last = 1'b0;
                        n_state    = S_CR;
                    end else begin
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            S_CR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_CR;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SIGN: begin
                if (!i_sts.neg) begin
                    n_state = S_CONV;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_MINUS;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (i_sts.lead_zero) begin
                    o_cmd.skip = 1'b1;
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.sel         = SEL_DIGIT;
                    o_cmd.shift_digit = 1'b1;
                    o_cmd.last        = i_sts.last_digit;
                    if (i_sts.last_digit) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/i2a_fmt_dp.sv
// Datapath of the integer to ASCII formatter: digit register, shift-add-3
// binary to BCD converter, digit counter, character mapping, output register.
// Depends on i2a_fmt_pkg.
module i2a_fmt_dp #(
    parameter int WORD_BITS = i2a_fmt_pkg::WORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  i2a_fmt_pkg::t_fmt_req  i_in_data,
    input  i2a_fmt_pkg::t_dp_cmd   i_cmd,
    output i2a_fmt_pkg::t_dp_sts   o_sts,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output i2a_fmt_pkg::t_fmt_char o_out_data
);
    import i2a_fmt_pkg::*;

    // decimal digits of 2**WORD_BITS, enough for any word
    localparam int NDEC   = (WORD_BITS * 30103) / 100000 + 1;
    localparam int HEXD   = (WORD_BITS + 3) / 4;
    localparam int DW     = 4 * NDEC;
    localparam int HEX_SH = DW - 4 * HEXD;
    localparam int BIN_SH = DW - WORD_BITS;
    localparam int CW     = $clog2(WORD_BITS + 1);

    logic [DW-1:0]        r_sh, n_sh;
    logic [WORD_BITS-1:0] r_src, n_src;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [2:0]           r_op;
    logic [7:0]           r_low;
    logic                 r_neg;
    logic                 r_out_valid;
    t_fmt_char            r_out;

    logic [WORD_BITS-1:0] word, mag;
    logic                 neg_in;
    logic [DW-1:0]        sh_adj;
    logic                 bin_mode, dec_mode;
    logic [3:0]           nib;
    logic [7:0]           digit_char, char_out;
    logic                 cnt_one;

    assign word   = WORD_BITS'(i_in_data.value);
    assign neg_in = (i_in_data.operation == OP_SDEC) && word[WORD_BITS-1];
    assign mag    = neg_in ? (~word + 1'b1) : word;

    assign bin_mode = (r_op == OP_BIN);
    assign dec_mode = (r_op == OP_SDEC) || (r_op == OP_UDEC);
    assign nib      = r_sh[DW-1 -: 4];
    assign cnt_one  = (r_cnt == CW'(1));

    // add 3 to every BCD digit of 5 or more before the next shift
    always_comb begin
        for (int g = 0; g < NDEC; g++) begin
            sh_adj[4*g +: 4] = (r_sh[4*g +: 4] >= 4'd5) ? r_sh[4*g +: 4] + 4'd3
                                                        : r_sh[4*g +: 4];
        end
    end

    always_comb begin
        if (bin_mode) begin
            digit_char = CH_0 + 8'(r_sh[DW-1]);
        end else if (dec_mode || nib < 4'd10) begin
            digit_char = CH_0 + 8'(nib & NIB_MASK);
        end else if (r_op == OP_HEX_UP) begin
            digit_char = CH_UP_A + 8'(nib - 4'd10);
        end else begin
            digit_char = CH_LO_A + 8'(nib - 4'd10);
        end
    end

    always_comb begin
        case (i_cmd.sel)
            SEL_LOW:   char_out = r_low;
            SEL_CR:    char_out = CH_CR;
            SEL_MINUS: char_out = CH_MINUS;
            SEL_DIGIT: char_out = digit_char;
            default:   char_out = digit_char;
        endcase
    end

    always_comb begin
        n_sh  = r_sh;
        n_src = r_src;
        n_cnt = r_cnt;
        if (i_cmd.load) begin
            n_src = mag;
            case (i_in_data.operation)
                OP_HEX_LO, OP_HEX_UP: begin
                    n_sh  = DW'(word) << HEX_SH;
                    n_cnt = CW'(HEXD);
                end
                OP_BIN: begin
                    n_sh  = DW'(word) << BIN_SH;
                    n_cnt = CW'(WORD_BITS);
                end
                default: begin
                    n_sh  = '0;
                    n_cnt = CW'(WORD_BITS);
                end
            endcase
        end else if (i_cmd.conv) begin
            n_sh  = {sh_adj[DW-2:0], r_src[WORD_BITS-1]};
            n_src = r_src << 1;
            n_cnt = cnt_one ? CW'(NDEC) : r_cnt - 1'b1;
        end else if (i_cmd.skip || i_cmd.shift_digit) begin
            n_sh  = bin_mode ? (r_sh << 1) : (r_sh << 4);
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh  <= n_sh;
        r_src <= n_src;
        r_cnt <= n_cnt;
        if (i_cmd.load) begin
            r_op  <= i_in_data.operation;
            r_low <= i_in_data.value[7:0];
            r_neg <= neg_in;
        end
        if (i_cmd.emit) begin
            r_out.out_char <= char_out;
            r_out.last     <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.op         = r_op;
        o_sts.is_nl      = (r_low == CH_NL);
        o_sts.neg        = r_neg;
        o_sts.conv_done  = cnt_one;
        o_sts.lead_zero  = !cnt_one && (bin_mode ? !r_sh[DW-1] : (nib == 4'd0));
        o_sts.last_digit = cnt_one;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### design/integer_to_ascii_formatter_top.sv
// Top level of the integer to ASCII formatter.
// Instantiates i2a_fmt_ctrl and i2a_fmt_dp; types from i2a_fmt_pkg.
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+------------------------------
//   in      | input     | i_in_valid / o_in_ready    | t_fmt_req  {operation, value}
//   out     | output    | o_out_valid / i_out_ready  | t_fmt_char {out_char, last}
//
// One request is in work at a time; o_in_ready is high only while the sequencer
// is idle, and the accept cycle loads the datapath. After that: literal/char emit
// the low byte, plus a CR after a literal newline; hex emits every digit
// (ceil(WORD_BITS/4)); binary skips leading zeros, then prints each remaining bit;
// decimal emits a minus sign (signed, negative only), shifts every input bit
// through the shift-add-3 BCD converter, skips leading zero digits, then prints
// each digit. Each character waits in the output register until taken, so a
// stalled sink freezes the sequencer on the next character; the next request may
// be accepted while the final character still waits. Reset (synchronous, active
// low) empties the output register and returns the sequencer to idle; no clearing
// pass is needed.
module integer_to_ascii_formatter_top #(
    parameter int WORD_BITS = i2a_fmt_pkg::WORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  i2a_fmt_pkg::t_fmt_req  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output i2a_fmt_pkg::t_fmt_char o_out_data
);
    import i2a_fmt_pkg::*;

    t_dp_cmd cmd;  // sequencer commands
    t_dp_sts sts;  // datapath status

    i2a_fmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_data.operation),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    i2a_fmt_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### dv/integer_to_ascii_formatter_top_tb.sv
// Testbench for integer_to_ascii_formatter_top: directed table plus random format requests.
// Self-checking against an in-bench formatter model; needs design/i2a_fmt_pkg.sv and the RTL.
module integer_to_ascii_formatter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2a_fmt_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 12;
    localparam int WORD_BITS    = WORD_BITS_DEF;
    localparam int HEX_DIGITS   = (WORD_BITS + 3) / 4;
    localparam int MAX_CHARS    = 32;           // longest printout of one request
    localparam int IDLE_PCT     = 27;           // chance per cycle that a side idles
    localparam int NUM_DIRECTED = 25;
    localparam int NUM_RANDOM   = 345;          // random requests, unused codes included
    localparam int HOLD_AT      = 100;          // random iteration that starts the sink hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_AT     = 200;          // random iteration where the source drains
    localparam int BURST_FROM   = 260;          // no idling on either side in this window
    localparam int BURST_TO     = 330;
    localparam int TAIL_CYCLES  = 100;          // > worst-case request latency
    localparam int CYCLE_LIMIT  = 300000;

    localparam logic [2:0]  OP_UNUSED = 3'd7;   // reserved code, block drops it silently
    localparam logic [63:0] WORD_MASK = (WORD_BITS >= 64) ? '1 :
                                        (64'd1 << WORD_BITS) - 64'd1;

    // One row of the directed table. Empty text means "ask the formatter model";
    // otherwise the text is the exact printout, last flag on its final character.
    typedef struct {
        logic [2:0]  op;
        logic [31:0] value;
        string       text;
    } t_dir_row;

    t_dir_row dir_rows [NUM_DIRECTED] = '{
        '{OP_SDEC,    32'h0000_0000, "0"},
        '{OP_SDEC,    32'h7FFF_FFFF, "2147483647"},
        '{OP_SDEC,    32'h8000_0000, "-2147483648"},   // most negative word
        '{OP_SDEC,    32'h8000_0001, "-2147483647"},
        '{OP_SDEC,    32'hFFFF_FFFF, "-1"},
        '{OP_UDEC,    32'h0000_0000, "0"},
        '{OP_UDEC,    32'hFFFF_FFFF, "4294967295"},
        '{OP_UDEC,    32'h3B9A_CA00, "1000000000"},
        '{OP_UDEC,    32'h3B9A_C9FF, "999999999"},
        '{OP_HEX_LO,  32'hDEAD_BEEF, "deadbeef"},
        '{OP_HEX_UP,  32'hDEAD_BEEF, "DEADBEEF"},
        '{OP_HEX_LO,  32'h0000_0000, "00000000"},
        '{OP_HEX_UP,  32'hFFFF_FFFF, "FFFFFFFF"},
        '{OP_BIN,     32'h0000_0000, "0"},              // binary zero prints one digit
        '{OP_BIN,     32'h0000_0001, "1"},
        '{OP_BIN,     32'hFFFF_FFFF, "11111111111111111111111111111111"},
        '{OP_BIN,     32'h8000_0000, "10000000000000000000000000000000"},
        '{OP_LITERAL, 32'h0000_007A, "z"},
        '{OP_LITERAL, 32'hFFFF_FF0A, ""},               // newline gets a trailing CR
        '{OP_LITERAL, 32'h0000_0000, ""},               // zero byte goes out as is
        '{OP_LITERAL, 32'h0000_000D, ""},
        '{OP_CHAR,    32'hFFFF_FF41, "A"},
        '{OP_CHAR,    32'h0000_000A, ""},               // char op: no CR after newline
        '{OP_CHAR,    32'h0000_00FF, ""},
        '{OP_UNUSED,  32'h1234_5678, ""}                // dropped, nothing printed
    };

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_fmt_req   i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_fmt_char  o_out_data;

    t_fmt_char  pending_chars[$];   // characters still owed by the block, oldest first
    int         err_count   = 0;
    int         cycle_count = 0;
    bit         idle_en     = 1'b1; // random idling on both sides
    bit         hold_start  = 1'b0; // source asks the sink for its long hold-off
    bit         hold_done   = 1'b0;

    integer_to_ascii_formatter_top #(
        .WORD_BITS (WORD_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Formatter model: appends the characters one request prints to pending_chars.
    function automatic void format_request(input t_fmt_req req);
        logic [63:0] word;
        logic [63:0] mag;
        logic [7:0]  text[$];
        logic [7:0]  digits[$];
        logic [7:0]  low;
        logic [7:0]  base;
        logic [3:0]  nib;
        bit          seen;
        word = {32'b0, req.value} & WORD_MASK;
        low  = req.value[7:0];
        case (req.operation)
            OP_LITERAL: begin
                text.push_back(low);
                if (low == CH_NL) text.push_back(CH_CR);
            end
            OP_SDEC, OP_UDEC: begin
                mag = word;
                if (req.operation == OP_SDEC && word[WORD_BITS-1]) begin
                    text.push_back(CH_MINUS);
                    mag = (~word + 64'd1) & WORD_MASK;
                end
                // peel digits off the bottom, print them top first
                do begin
                    digits.push_front(CH_0 + 8'(mag % 64'd10));
                    mag = mag / 64'd10;
                end while (mag != 0);
                foreach (digits[i])
                    if (text.size() < MAX_CHARS) text.push_back(digits[i]);
            end
            OP_HEX_LO, OP_HEX_UP: begin
                base = (req.operation == OP_HEX_LO) ? CH_LO_A : CH_UP_A;
                for (int i = HEX_DIGITS - 1; i >= 0 && text.size() < MAX_CHARS; i--) begin
                    nib = 4'(word >> (i * 4)) & NIB_MASK;
                    text.push_back(nib < 4'd10 ? CH_0 + 8'(nib) : base + 8'(nib - 4'd10));
                end
            end
            OP_BIN: begin
                seen = 1'b0;
                for (int i = 63; i >= 0; i--) begin
                    if (word[i]) seen = 1'b1;
                    if (seen && text.size() < MAX_CHARS)
                        text.push_back(word[i] ? CH_0 + 8'd1 : CH_0);
                end
                if (!seen) text.push_back(CH_0);
            end
            OP_CHAR: text.push_back(low);
            default: ;
        endcase
        foreach (text[i])
            pending_chars.push_back('{out_char: text[i], last: 1'(i == text.size() - 1)});
    endfunction

    // Puts one request on the input channel and returns at the edge that takes it.
    // Random gaps come first; valid then stays up until o_in_ready.
    task automatic offer_request(input t_fmt_req req);
        while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Source: reset, directed table, then random requests.
    initial begin : source
        t_fmt_req    req;
        logic [2:0]  op;
        logic [31:0] val;
        logic [31:0] p10;
        int          n_sent;
        int          iter;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            req = '{operation: dir_rows[r].op, value: dir_rows[r].value};
            offer_request(req);
            if (dir_rows[r].text.len() == 0)
                format_request(req);
            else
                for (int c = 0; c < dir_rows[r].text.len(); c++)
                    pending_chars.push_back('{out_char: dir_rows[r].text[c],
                                              last: 1'(c == dir_rows[r].text.len() - 1)});
        end

        n_sent = 0;
        iter   = 0;
        while (n_sent < NUM_RANDOM) begin
            // sink goes quiet for a long stretch while we keep pushing requests
            if (iter == HOLD_AT) hold_start = 1'b1;
            // let the block run dry once before carrying on
            if (iter == DRAIN_AT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_chars.size() != 0) @(posedge i_clk);
            end
            idle_en = !(iter >= BURST_FROM && iter < BURST_TO);

            op = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 5))
                0: val = $urandom_range(0, 20);
                1: val = 32'h7FFF_FFFE + $urandom_range(0, 3);   // around the sign flip
                2: val = 32'hFFFF_FFFF - $urandom_range(0, 3);
                3: begin
                    p10 = 32'd1;
                    repeat ($urandom_range(0, 9)) p10 = p10 * 32'd10;
                    val = p10 + $urandom_range(0, 2) - 32'd1;    // digit count edges
                end
                4: val = $urandom >> $urandom_range(0, 31);      // varied leading zeros
                default: val = $urandom;
            endcase
            if ((op == OP_LITERAL || op == OP_CHAR) && $urandom_range(0, 3) == 0)
                val[7:0] = CH_NL;

            req = '{operation: op, value: val};
            offer_request(req);
            format_request(req);
            n_sent++;
            iter++;
        end
        i_in_valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        // quiet tail: catches stray characters after the last expected one
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Sink: random ready, plus one long hold-off when the source asks for it.
    initial begin : sink
        int held;
        forever begin
            @(posedge i_clk);
            if (hold_start && !hold_done) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge i_clk);
            end
            i_out_ready <= !idle_en || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Every character taken off the output is matched against the oldest owed one.
    always @(posedge i_clk) begin : char_check
        t_fmt_char want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected word: out_char 0x%02h last %0b",
                       o_out_data.out_char, o_out_data.last);
                err_count++;
            end else begin
                want = pending_chars.pop_front();
                if (o_out_data.out_char !== want.out_char) begin
                    $error("out_char: expected 0x%02h, actual 0x%02h",
                           want.out_char, o_out_data.out_char);
                    err_count++;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, o_out_data.last);
                    err_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
